// ----- src/rrq_pkg.sv -----
// Types, codes and sizes shared by the round-robin run queue and its cells.
package rrq_pkg;

    localparam int SLOTS = 16;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_NEXT    = 3'd2,
        CMD_YIELD   = 3'd3,
        CMD_REQUEUE = 3'd4,
        CMD_UNLOCK  = 3'd5,
        CMD_UPDATE  = 3'd6,
        CMD_LOOKUP  = 3'd7
    } cmd_e;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [1:0] ST_RUNNABLE = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;

    typedef struct packed {
        cmd_e        command;
        logic [15:0] thread_id;
        logic [1:0]  new_state;
        logic [7:0]  mutex_id;
        logic        mutex_wait_set;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [1:0]  result_state;
    } res_t;

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  state;
        logic [7:0]  wait_mutex;
        logic        wait_valid;
    } entry_t;

    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,
        ACT_SHIFT = 2'd1,
        ACT_LOAD  = 2'd2
    } cell_act_e;

    typedef struct packed {
        logic      occupied;
        cell_act_e action;
    } cell_ctrl_t;

endpackage

// ----- src/rrq_cell.sv -----
// One queue slot: holds an entry, matches it against the command, shifts or loads.
module rrq_cell (
    input  logic                clk,
    input  rrq_pkg::cell_ctrl_t ctrl,
    input  rrq_pkg::cmd_t       key,
    input  rrq_pkg::entry_t     right,
    input  rrq_pkg::entry_t     load_val,
    output rrq_pkg::entry_t     entry,
    output logic                match
);

    rrq_pkg::entry_t entry_reg;
    rrq_pkg::entry_t entry_next;
    logic            hit;

    always_comb
    begin
        unique case (key.command)
            rrq_pkg::CMD_ADD:     hit = 1'b0;
            rrq_pkg::CMD_NEXT:    hit = (entry_reg.state == rrq_pkg::ST_RUNNABLE);
            rrq_pkg::CMD_YIELD:   hit = (entry_reg.state == rrq_pkg::ST_RUNNING);
            rrq_pkg::CMD_UNLOCK:  hit = entry_reg.wait_valid
                                        && (entry_reg.wait_mutex == key.mutex_id);
            rrq_pkg::CMD_REMOVE,
            rrq_pkg::CMD_REQUEUE,
            rrq_pkg::CMD_UPDATE,
            rrq_pkg::CMD_LOOKUP:  hit = (entry_reg.id == key.thread_id);
            default:              hit = 1'b0;
        endcase
    end

    assign match = ctrl.occupied && hit;

    always_comb
    begin
        unique case (ctrl.action)
            rrq_pkg::ACT_SHIFT: entry_next = right;
            rrq_pkg::ACT_LOAD:  entry_next = load_val;
            default:            entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- src/round_robin_thread_run_queue.sv -----
// Top level of the round-robin thread run queue: control, cell chain and result register.
//
// Ordered run queue of up to rrq_pkg::SLOTS thread entries held in a chain of cells,
// front of the queue in cell 0. Each command passes through the states idle, match and
// apply: in idle its transfer loads it into the command register, in match every cell
// compares its entry in parallel and the match vector is registered, and in apply the
// first match is picked, the chain shifts one step toward the front to close the gap,
// the moved or new entry loads into its cell and the result is written. The next
// command is taken once the block is back in idle; a result waits in its own register,
// and the apply step holds while an earlier result has not yet been transferred.
// Searches pick the entry nearest the front. Slots above the entry count hold stale
// data and are never matched. Commands that find nothing return status "no match" with
// zero id and state; an add to a full queue returns status "full".
module round_robin_thread_run_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  rrq_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output rrq_pkg::res_t res
);

    localparam int SLOTS   = rrq_pkg::SLOTS;
    localparam int CNT_W   = rrq_pkg::CNT_W;
    localparam int ENTRY_W = $bits(rrq_pkg::entry_t);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    rrq_pkg::cmd_t       cmd_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SLOTS-1:0]    match_reg;
    logic [SLOTS-1:0]    match_vec;
    logic                res_valid_reg, res_valid_next;
    rrq_pkg::res_t       res_reg, res_next;

    rrq_pkg::entry_t     cell_entry [SLOTS];
    rrq_pkg::cell_ctrl_t cell_ctrl  [SLOTS];
    rrq_pkg::entry_t     load_val;

    logic [SLOTS-1:0]    first_hot;
    logic [SLOTS-1:0]    ge_mask;
    logic [ENTRY_W-1:0]  sel_bits;
    rrq_pkg::entry_t     sel;
    rrq_pkg::entry_t     moved;
    logic                found;
    logic                full;
    logic                commit;
    logic                is_move;
    logic                do_shift;
    logic                do_load_last;
    logic                do_load_first;
    logic                do_add;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Isolate the frontmost match and mark every slot from it to the back.
    assign first_hot = match_reg & (~match_reg + SLOTS'(1));
    assign ge_mask   = ~(first_hot - SLOTS'(1));
    assign found     = |match_reg;
    assign full      = (count_reg == CNT_W'(SLOTS));

    // Apply only when the result register is free or drains this cycle.
    assign commit = (state_reg == S_APPLY) && (!res_valid_reg || res_ready);

    always_comb
    begin
        sel_bits = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel_bits = sel_bits | (cell_entry[i] & {ENTRY_W{first_hot[i]}});
        end
        sel = rrq_pkg::entry_t'(sel_bits);
    end

    // Work out the entry that goes to the back, and what each command loads.
    always_comb
    begin
        moved   = sel;
        is_move = 1'b0;
        unique case (cmd_reg.command)
            rrq_pkg::CMD_NEXT,
            rrq_pkg::CMD_REQUEUE:
            begin
                is_move = 1'b1;
            end
            rrq_pkg::CMD_YIELD:
            begin
                is_move     = 1'b1;
                moved.state = rrq_pkg::ST_RUNNABLE;
            end
            rrq_pkg::CMD_UNLOCK:
            begin
                is_move          = 1'b1;
                moved.state      = rrq_pkg::ST_RUNNABLE;
                moved.wait_mutex = '0;
                moved.wait_valid = 1'b0;
            end
            default:
            begin
                is_move = 1'b0;
            end
        endcase

        load_val = moved;
        if (cmd_reg.command == rrq_pkg::CMD_ADD)
        begin
            load_val.id         = cmd_reg.thread_id;
            load_val.state      = cmd_reg.new_state;
            load_val.wait_mutex = '0;
            load_val.wait_valid = 1'b0;
        end
        else if (cmd_reg.command == rrq_pkg::CMD_UPDATE)
        begin
            load_val.id         = sel.id;
            load_val.state      = cmd_reg.new_state;
            load_val.wait_mutex = cmd_reg.mutex_wait_set ? cmd_reg.mutex_id : 8'd0;
            load_val.wait_valid = cmd_reg.mutex_wait_set;
        end
    end

    assign do_shift      = commit && found
                           && (is_move || (cmd_reg.command == rrq_pkg::CMD_REMOVE));
    assign do_load_last  = commit && found && is_move;
    assign do_load_first = commit && found && (cmd_reg.command == rrq_pkg::CMD_UPDATE);
    assign do_add        = commit && !full && (cmd_reg.command == rrq_pkg::CMD_ADD);

    // Chain of cells; each one takes its right neighbor on a shift.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        logic below_last;
        logic at_last;
        logic at_count;

        assign below_last = (CNT_W'(i + 1) < count_reg);
        assign at_last    = (count_reg == CNT_W'(i + 1));
        assign at_count   = (count_reg == CNT_W'(i));

        always_comb
        begin
            cell_ctrl[i].occupied = (CNT_W'(i) < count_reg);
            priority if ((do_load_last && at_last) || (do_load_first && first_hot[i])
                         || (do_add && at_count))
            begin
                cell_ctrl[i].action = rrq_pkg::ACT_LOAD;
            end
            else if (do_shift && ge_mask[i] && below_last)
            begin
                cell_ctrl[i].action = rrq_pkg::ACT_SHIFT;
            end
            else
            begin
                cell_ctrl[i].action = rrq_pkg::ACT_HOLD;
            end
        end

        rrq_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl[i]),
            .key      (cmd_reg),
            .right    ((i == SLOTS - 1) ? cell_entry[i] : cell_entry[(i + 1) % SLOTS]),
            .load_val (load_val),
            .entry    (cell_entry[i]),
            .match    (match_vec[i])
        );
    end

    // Result and count for the command being applied.
    always_comb
    begin
        res_next   = res_reg;
        count_next = count_reg;
        if (commit)
        begin
            res_next.status       = rrq_pkg::STATUS_MISS;
            res_next.result_id    = '0;
            res_next.result_state = '0;
            if (cmd_reg.command == rrq_pkg::CMD_ADD)
            begin
                if (full)
                begin
                    res_next.status = rrq_pkg::STATUS_FULL;
                end
                else
                begin
                    res_next.status       = rrq_pkg::STATUS_OK;
                    res_next.result_id    = cmd_reg.thread_id;
                    res_next.result_state = cmd_reg.new_state;
                    count_next            = count_reg + CNT_W'(1);
                end
            end
            else if (found)
            begin
                res_next.status = rrq_pkg::STATUS_OK;
                unique case (cmd_reg.command)
                    rrq_pkg::CMD_REMOVE:
                    begin
                        res_next.result_id = cmd_reg.thread_id;
                        count_next         = count_reg - CNT_W'(1);
                    end
                    rrq_pkg::CMD_UPDATE:
                    begin
                        res_next.result_id    = cmd_reg.thread_id;
                        res_next.result_state = cmd_reg.new_state;
                    end
                    rrq_pkg::CMD_LOOKUP:
                    begin
                        res_next.result_id    = sel.id;
                        res_next.result_state = sel.state;
                    end
                    default:
                    begin
                        res_next.result_id    = moved.id;
                        res_next.result_state = moved.state;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers: hold the command, the match vector and the result.
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_MATCH)
        begin
            match_reg <= match_vec;
        end
        res_reg <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("entry count above slot count");

    a_transfer_to_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == S_MATCH))
        else $error("command transfer did not start a match cycle");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((count_reg == $past(count_reg))
                  || (count_reg == $past(count_reg) + CNT_W'(1))
                  || (count_reg + CNT_W'(1) == $past(count_reg))))
        else $error("entry count moved by more than one");

    a_result_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid_reg && !commit) |=> !res_valid_reg)
        else $error("result raised without an apply step");

endmodule

// ----- sim/round_robin_thread_run_queue_tb.sv -----
// Testbench for the round-robin thread run queue: directed and random commands, checked in order.
module round_robin_thread_run_queue_tb;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_GAP       = 14;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_OFF      = 300;
    localparam int HOLD_AT       = 400;

    // Shadow copy of the run queue. Every accepted command updates it and
    // pushes the one result that the block must return for it.
    class run_queue_model;
        rrq_pkg::entry_t slots [rrq_pkg::SLOTS];
        int unsigned     count;
        rrq_pkg::res_t   pending_results [$];
        int unsigned     checked;
        int unsigned     errors;

        function new();
            count   = 0;
            checked = 0;
            errors  = 0;
        endfunction

        function int find_id(logic [15:0] id);
            for (int i = 0; i < count; i++)
                if (slots[i].id == id)
                    return i;
            return -1;
        endfunction

        function int find_state(logic [1:0] st);
            for (int i = 0; i < count; i++)
                if (slots[i].state == st)
                    return i;
            return -1;
        endfunction

        function int find_waiter(logic [7:0] m);
            for (int i = 0; i < count; i++)
                if (slots[i].wait_valid && slots[i].wait_mutex == m)
                    return i;
            return -1;
        endfunction

        // Pull the entry out, close the gap and place it last.
        function int move_to_back(int idx);
            rrq_pkg::entry_t held;
            held = slots[idx];
            for (int j = idx; j + 1 < count; j++)
                slots[j] = slots[j + 1];
            slots[count - 1] = held;
            return count - 1;
        endfunction

        function void accept_command(rrq_pkg::cmd_t c);
            rrq_pkg::res_t r;
            int            k;
            int            p;
            r = '{status: rrq_pkg::STATUS_MISS, result_id: '0, result_state: '0};
            case (c.command)
                rrq_pkg::CMD_ADD:
                begin
                    if (count >= rrq_pkg::SLOTS)
                        r.status = rrq_pkg::STATUS_FULL;
                    else
                    begin
                        slots[count] = '{id: c.thread_id, state: c.new_state,
                                         wait_mutex: '0, wait_valid: 1'b0};
                        count++;
                        r = '{status: rrq_pkg::STATUS_OK, result_id: c.thread_id,
                              result_state: c.new_state};
                    end
                end
                rrq_pkg::CMD_REMOVE:
                begin
                    k = find_id(c.thread_id);
                    if (k >= 0)
                    begin
                        for (int j = k; j + 1 < count; j++)
                            slots[j] = slots[j + 1];
                        count--;
                        r = '{status: rrq_pkg::STATUS_OK, result_id: c.thread_id,
                              result_state: '0};
                    end
                end
                rrq_pkg::CMD_NEXT, rrq_pkg::CMD_YIELD, rrq_pkg::CMD_REQUEUE,
                rrq_pkg::CMD_UNLOCK:
                begin
                    if (c.command == rrq_pkg::CMD_NEXT)
                        k = find_state(rrq_pkg::ST_RUNNABLE);
                    else if (c.command == rrq_pkg::CMD_YIELD)
                        k = find_state(rrq_pkg::ST_RUNNING);
                    else if (c.command == rrq_pkg::CMD_REQUEUE)
                        k = find_id(c.thread_id);
                    else
                        k = find_waiter(c.mutex_id);
                    if (k >= 0)
                    begin
                        if (c.command == rrq_pkg::CMD_YIELD)
                            slots[k].state = rrq_pkg::ST_RUNNABLE;
                        if (c.command == rrq_pkg::CMD_UNLOCK)
                        begin
                            slots[k].wait_valid = 1'b0;
                            slots[k].wait_mutex = '0;
                            slots[k].state      = rrq_pkg::ST_RUNNABLE;
                        end
                        p = move_to_back(k);
                        r = '{status: rrq_pkg::STATUS_OK, result_id: slots[p].id,
                              result_state: slots[p].state};
                    end
                end
                rrq_pkg::CMD_UPDATE:
                begin
                    k = find_id(c.thread_id);
                    if (k >= 0)
                    begin
                        slots[k].state      = c.new_state;
                        slots[k].wait_valid = c.mutex_wait_set;
                        slots[k].wait_mutex = c.mutex_wait_set ? c.mutex_id : 8'd0;
                        r = '{status: rrq_pkg::STATUS_OK, result_id: c.thread_id,
                              result_state: c.new_state};
                    end
                end
                default:
                begin
                    k = find_id(c.thread_id);
                    if (k >= 0)
                        r = '{status: rrq_pkg::STATUS_OK, result_id: slots[k].id,
                              result_state: slots[k].state};
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(rrq_pkg::res_t got);
            rrq_pkg::res_t want;
            checked++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d id %h state %0d",
                         $time, got.status, got.result_id, got.result_state);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.result_id !== want.result_id)
            begin
                $display("%0t: result_id mismatch: expected %h, actual %h",
                         $time, want.result_id, got.result_id);
                errors++;
            end
            if (got.result_state !== want.result_state)
            begin
                $display("%0t: result_state mismatch: expected %0d, actual %0d",
                         $time, want.result_state, got.result_state);
                errors++;
            end
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_ready;
    rrq_pkg::cmd_t cmd       = '0;
    logic          res_valid;
    logic          res_ready = 1'b1;
    rrq_pkg::res_t res;

    run_queue_model queue_model = new();

    // Both sides drop their idle gaps while this is set.
    bit          quiet_phase = 1'b0;
    int unsigned fill_target = 8;
    logic [15:0] id_pool    [8];
    logic [7:0]  mutex_pool [4];

    round_robin_thread_run_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    function automatic int draw_gap();
        return quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic rrq_pkg::cmd_t make_command(rrq_pkg::cmd_e op, logic [15:0] id,
                                                   logic [1:0] st, logic [7:0] m, logic w);
        rrq_pkg::cmd_t c;
        c.command        = op;
        c.thread_id      = id;
        c.new_state      = st;
        c.mutex_id       = m;
        c.mutex_wait_set = w;
        return c;
    endfunction

    // Favor ids that are in the queue so that searches mostly hit; mix in
    // pooled and fully random ids so that misses and every id bit show up.
    function automatic logic [15:0] pick_id();
        if (queue_model.count > 0 && $urandom_range(0, 3) != 0)
            return queue_model.slots[$urandom_range(0, queue_model.count - 1)].id;
        if ($urandom_range(0, 1) != 0)
            return id_pool[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    function automatic rrq_pkg::cmd_t random_command();
        rrq_pkg::cmd_t c;
        int            waiters [$];
        int            r;
        c.command        = rrq_pkg::cmd_e'($urandom_range(0, 7));
        c.thread_id      = 16'($urandom);
        c.new_state      = 2'($urandom);
        c.mutex_id       = 8'($urandom);
        c.mutex_wait_set = 1'($urandom);
        r = $urandom_range(0, 99);
        // Keep a share of raw noise with fully random fields.
        if (r < 10)
            return c;
        // Steer the fill level toward the current target with add and remove.
        if (r < 40)
            c.command = (queue_model.count < fill_target) ? rrq_pkg::CMD_ADD
                                                          : rrq_pkg::CMD_REMOVE;
        else
        begin
            case ($urandom_range(0, 5))
                0:       c.command = rrq_pkg::CMD_NEXT;
                1:       c.command = rrq_pkg::CMD_YIELD;
                2:       c.command = rrq_pkg::CMD_REQUEUE;
                3:       c.command = rrq_pkg::CMD_UNLOCK;
                4:       c.command = rrq_pkg::CMD_UPDATE;
                default: c.command = rrq_pkg::CMD_LOOKUP;
            endcase
        end
        c.thread_id = pick_id();
        if ($urandom_range(0, 3) != 0)
            c.mutex_id = mutex_pool[$urandom_range(0, 3)];
        // Aim most unlocks at a mutex that some entry is really waiting on.
        if (c.command == rrq_pkg::CMD_UNLOCK && $urandom_range(0, 2) != 0)
        begin
            for (int i = 0; i < queue_model.count; i++)
                if (queue_model.slots[i].wait_valid)
                    waiters.push_back(i);
            if (waiters.size() > 0)
                c.mutex_id = queue_model.slots[waiters[$urandom_range(0, waiters.size() - 1)]]
                             .wait_mutex;
        end
        return c;
    endfunction

    // Offer one command after its idle gap and hold it until the transfer.
    // With no gap, valid stays high and only the payload advances.
    task automatic drive_command(rrq_pkg::cmd_t c);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
        queue_model.accept_command(c);
    endtask

    // Result side: draw a stall per result, hold ready low for it, then take
    // the next transfer. Once, hold off for a long stretch so the block backs
    // up and stalls its input while the sender keeps offering.
    initial
    begin : result_side
        int gap;
        bit held_off;
        held_off = 1'b0;
        forever
        begin
            gap = draw_gap();
            if (!held_off && queue_model.checked == HOLD_AT)
            begin
                gap      = HOLD_OFF;
                held_off = 1'b1;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                res_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
                res_ready <= 1'b1;
            end
            do
                @(posedge clk);
            while (!res_valid);
            queue_model.check_result(res);
        end
    end

    initial
    begin : stimulus
        int waited;
        for (int i = 0; i < 8; i++)
            id_pool[i] = 16'($urandom);
        for (int i = 0; i < 4; i++)
            mutex_pool[i] = 8'($urandom);
        mutex_pool[0] = 8'h00;
        mutex_pool[1] = 8'hFF;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Searches on an empty queue find nothing.
        drive_command(make_command(rrq_pkg::CMD_LOOKUP, 16'h0000, 2'd0, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_NEXT,   16'hFFFF, 2'd3, 8'hFF, 1'b1));
        drive_command(make_command(rrq_pkg::CMD_UNLOCK, 16'h0000, 2'd0, 8'hFF, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_REMOVE, 16'hFFFF, 2'd0, 8'h00, 1'b0));

        // Extreme ids, every state, a duplicate id, then fill up the queue.
        drive_command(make_command(rrq_pkg::CMD_ADD, 16'h0000, 2'd0, 8'hFF, 1'b1));
        drive_command(make_command(rrq_pkg::CMD_ADD, 16'hFFFF, 2'd3, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_ADD, 16'h0001, 2'd1, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_ADD, 16'h0000, 2'd2, 8'h00, 1'b0));
        for (int i = 0; i < rrq_pkg::SLOTS - 4; i++)
            drive_command(make_command(rrq_pkg::CMD_ADD, 16'h1000 + 16'(i), 2'(i),
                                       8'h00, 1'b0));

        // Add to a full queue is refused.
        drive_command(make_command(rrq_pkg::CMD_ADD, 16'hABCD, 2'd1, 8'h00, 1'b0));

        // Exercise each moving command and the wait on a mutex.
        drive_command(make_command(rrq_pkg::CMD_NEXT,    16'h0000, 2'd0, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_YIELD,   16'h0000, 2'd0, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_REQUEUE, 16'hFFFF, 2'd0, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_UPDATE,  16'h0001, 2'd2, 8'hFF, 1'b1));
        drive_command(make_command(rrq_pkg::CMD_UNLOCK,  16'h0000, 2'd0, 8'hFF, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_UPDATE,  16'hFFFF, 2'd1, 8'h5A, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_LOOKUP,  16'hFFFF, 2'd0, 8'h00, 1'b0));
        drive_command(make_command(rrq_pkg::CMD_REMOVE,  16'h0000, 2'd0, 8'h00, 1'b0));

        // Random part: move the fill target now and then so the queue swings
        // between empty and full, with stretches that drop all idle gaps.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                fill_target = $urandom_range(0, rrq_pkg::SLOTS);
            quiet_phase = (i % 300) >= 240;
            drive_command(random_command());
        end
        quiet_phase = 1'b0;
        @(negedge clk);
        cmd_valid <= 1'b0;

        // Drain outstanding results, then let a few more cycles pass so that
        // a stray extra result would still be caught.
        waited = 0;
        while (queue_model.pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
            $display("Verification failed");
        else
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
            if (queue_model.pending_results.size() != 0)
            begin
                $display("%0t: %0d results never arrived",
                         $time, queue_model.pending_results.size());
                queue_model.errors++;
            end
            if (queue_model.errors == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin : watchdog
        #(600000 * (CLK_HIGH + CLK_LOW));
        $display("Verification failed");
        $finish;
    end

endmodule
